### rtl/skpt_pkg.sv
package skpt_pkg;

    // Glyph count is capped at this many characters
    localparam int unsigned MAX_GLYPHS = 256;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned OFF_W   = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned GC_W    = 9;
    localparam int unsigned IN_W    = 24;
    localparam int unsigned OUT_W   = 40;

    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    localparam logic CFG_FIRST_CODE  = 1'b0;
    localparam logic CFG_GLYPH_COUNT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_DEL,
        S_INS,
        S_DONE
    } t_state;

    // One stored pair, characters relative to first_code
    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [CHAR_W-1:0] right;
        logic [CHAR_W-1:0] left;
    } t_pair;

endpackage

### rtl/skpt_ram.sv
module skpt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sorted_kern_pair_table_core.sv
// Kerning pair table kept sorted by (left, right) in one RAM of MAX_PAIRS entries, one
// item at a time. Input tuser carries the kind (lookup, set, clear); a set with a zero
// offset removes the pair. Every in-range lookup or set walks the stored pairs from
// position 0, one RAM read per cycle, up to the insertion point; an insert or delete
// then moves the tail one entry per cycle through the same RAM port. A clear or an
// out-of-range character skips the walk. The next word is taken once the result is
// loaded. The first-pair position for first_char is picked up during the walk. The
// output word is registered, so the next item is taken while a result waits. Write
// configuration only while no item is in flight; the characters are checked against
// it when a word is taken.
module sorted_kern_pair_table_core #(
    parameter int MAX_PAIRS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: first_char[7:0], second_char[15:8], new_offset[23:16]
    input  logic [23:0] i_s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: found[0], pair_offset[8:1], pair_position[16:9], pair_total[25:17],
    //        first_entry_valid[26], first_entry_position[34:27], status[36:35], zero[39:37]
    output logic [39:0] o_m_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_idx,
    input  logic [8:0]  i_cfg_data
);

    import skpt_pkg::*;

    localparam int PW = $clog2(MAX_PAIRS);
    localparam int CW = $clog2(MAX_PAIRS + 1);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_ptr, n_ptr;
    logic               r_dv, n_dv;
    logic [CW-1:0]      r_didx, n_didx;
    logic [CW-1:0]      r_at, n_at;
    logic               r_found, n_found;
    logic [OFF_W-1:0]   r_hit_off, n_hit_off;
    logic               r_fe_ok, n_fe_ok;
    logic [CW-1:0]      r_fe_pos, n_fe_pos;
    logic [STAT_W-1:0]  r_status, n_status;
    logic [KIND_W-1:0]  r_kind, n_kind;
    logic [CHAR_W-1:0]  r_l1, n_l1;
    logic [CHAR_W-1:0]  r_l2, n_l2;
    logic [OFF_W-1:0]   r_off, n_off;
    logic               r_m_valid, n_m_valid;
    logic [OUT_W-1:0]   r_m_data, n_m_data;
    logic [CHAR_W-1:0]  r_fc;
    logic [GC_W-1:0]    r_gc;

    logic               w_re, w_we;
    logic [PW-1:0]      w_raddr, w_waddr;
    t_pair              w_wdata, w_rd;
    logic [IN_W-1:0]    w_rdata_raw;
    logic [GC_W-1:0]    w_cnt, w_d1, w_d2;
    logic               w_bad;
    logic [15:0]        w_key_d, w_key;
    logic [CW-1:0]      w_didx_dec, w_didx_inc, w_ptr_dec, w_at_inc;

    skpt_ram #(
        .WIDTH (IN_W),
        .DEPTH (MAX_PAIRS)
    ) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    assign w_rd = t_pair'(w_rdata_raw);

    // Out-of-range test; a code below first_code wraps above 256 and fails too
    assign w_cnt = (r_gc > GC_W'(MAX_GLYPHS)) ? GC_W'(MAX_GLYPHS) : r_gc;
    assign w_d1  = {1'b0, i_s_axis_tdata[7:0]}  - {1'b0, r_fc};
    assign w_d2  = {1'b0, i_s_axis_tdata[15:8]} - {1'b0, r_fc};
    assign w_bad = (w_d1 >= w_cnt) || (w_d2 >= w_cnt);

    assign w_key_d    = {w_rd.left, w_rd.right};
    assign w_key      = {r_l1, r_l2};
    assign w_didx_dec = r_didx - CW'(1);
    assign w_didx_inc = r_didx + CW'(1);
    assign w_ptr_dec  = r_ptr - CW'(1);
    assign w_at_inc   = r_at + CW'(1);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_dv      = 1'b0;
        n_didx    = r_didx;
        n_at      = r_at;
        n_found   = r_found;
        n_hit_off = r_hit_off;
        n_fe_ok   = r_fe_ok;
        n_fe_pos  = r_fe_pos;
        n_status  = r_status;
        n_kind    = r_kind;
        n_l1      = r_l1;
        n_l2      = r_l2;
        n_off     = r_off;
        n_m_valid = r_m_valid & ~i_m_axis_tready;
        n_m_data  = r_m_data;
        w_re      = 1'b0;
        w_raddr   = '0;
        w_we      = 1'b0;
        w_waddr   = '0;
        w_wdata   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_kind   = i_s_axis_tuser;
                    n_l1     = w_d1[CHAR_W-1:0];
                    n_l2     = w_d2[CHAR_W-1:0];
                    n_off    = i_s_axis_tdata[23:16];
                    n_found  = 1'b0;
                    n_fe_ok  = 1'b0;
                    n_fe_pos = '0;
                    n_status = ST_OK;
                    n_ptr    = '0;
                    n_at     = '0;
                    if (i_s_axis_tuser == KIND_CLEAR) begin
                        n_count = '0;
                        n_state = S_DONE;
                    end else if (w_bad) begin
                        n_status = ST_RANGE;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_dv && (w_rd.left == r_l1) && !r_fe_ok) begin
                    n_fe_ok  = 1'b1;
                    n_fe_pos = r_didx;
                end
                // stop at the first stored key not below the wanted one
                if (r_dv && (w_key_d >= w_key)) begin
                    n_at      = r_didx;
                    n_found   = (w_key_d == w_key);
                    n_hit_off = w_rd.off;
                    n_state   = S_DECIDE;
                end else if (r_ptr == r_count) begin
                    n_at    = r_count;
                    n_state = S_DECIDE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_ptr[PW-1:0];
                    n_dv    = 1'b1;
                    n_didx  = r_ptr;
                    n_ptr   = r_ptr + CW'(1);
                end
            end
            S_DECIDE: begin
                n_state = S_DONE;
                if (r_kind == KIND_SET) begin
                    if (r_found) begin
                        if (r_off != '0) begin
                            w_we      = 1'b1;
                            w_waddr   = r_at[PW-1:0];
                            w_wdata   = '{off: r_off, right: r_l2, left: r_l1};
                            n_hit_off = r_off;
                        end else begin
                            n_found = 1'b0;
                            if (r_fe_pos == r_at) begin
                                n_fe_ok = 1'b0;
                            end
                            n_ptr   = w_at_inc;
                            n_state = S_DEL;
                        end
                    end else if (r_off != '0) begin
                        if (r_count == CW'(MAX_PAIRS)) begin
                            n_status = ST_FULL;
                        end else begin
                            if (!r_fe_ok) begin
                                n_fe_ok  = 1'b1;
                                n_fe_pos = r_at;
                            end
                            n_ptr   = r_count;
                            n_state = S_INS;
                        end
                    end
                end
            end
            S_DEL: begin
                // move entry down by one; the one after the removed pair may
                // become the first pair of its character
                if (r_dv) begin
                    w_we    = 1'b1;
                    w_waddr = w_didx_dec[PW-1:0];
                    w_wdata = w_rd;
                    if ((r_didx == w_at_inc) && (w_rd.left == r_l1) && !r_fe_ok) begin
                        n_fe_ok = 1'b1;
                    end
                end
                if (r_ptr < r_count) begin
                    w_re    = 1'b1;
                    w_raddr = r_ptr[PW-1:0];
                    n_dv    = 1'b1;
                    n_didx  = r_ptr;
                    n_ptr   = r_ptr + CW'(1);
                end else if (!r_dv) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_INS: begin
                // move tail up by one, from the top down, then drop the new pair in
                if (r_dv) begin
                    w_we    = 1'b1;
                    w_waddr = w_didx_inc[PW-1:0];
                    w_wdata = w_rd;
                end
                if (r_ptr > r_at) begin
                    w_re    = 1'b1;
                    w_raddr = w_ptr_dec[PW-1:0];
                    n_dv    = 1'b1;
                    n_didx  = w_ptr_dec;
                    n_ptr   = w_ptr_dec;
                end else if (!r_dv) begin
                    w_we      = 1'b1;
                    w_waddr   = r_at[PW-1:0];
                    w_wdata   = '{off: r_off, right: r_l2, left: r_l1};
                    n_count   = r_count + CW'(1);
                    n_found   = 1'b1;
                    n_hit_off = r_off;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {3'b000,
                                 r_status,
                                 r_fe_ok ? CHAR_W'(r_fe_pos) : CHAR_W'(0),
                                 r_fe_ok,
                                 GC_W'(r_count),
                                 r_found ? CHAR_W'(r_at) : CHAR_W'(0),
                                 r_found ? r_hit_off : OFF_W'(0),
                                 r_found};
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_dv      <= 1'b0;
            r_m_valid <= 1'b0;
            r_fc      <= 8'd32;
            r_gc      <= 9'd96;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dv      <= n_dv;
            r_m_valid <= n_m_valid;
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_FIRST_CODE:  r_fc <= i_cfg_data[CHAR_W-1:0];
                    CFG_GLYPH_COUNT: r_gc <= i_cfg_data;
                    default:         r_gc <= r_gc;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_didx    <= n_didx;
        r_at      <= n_at;
        r_found   <= n_found;
        r_hit_off <= n_hit_off;
        r_fe_ok   <= n_fe_ok;
        r_fe_pos  <= n_fe_pos;
        r_status  <= n_status;
        r_kind    <= n_kind;
        r_l1      <= n_l1;
        r_l2      <= n_l2;
        r_off     <= n_off;
        r_m_data  <= n_m_data;
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PAIRS))
        else $error("pair count above table size");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == KIND_CLEAR))
        |=> (r_count == '0))
        else $error("clear did not empty table");

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS && n_state == S_DONE)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not bump pair count");

    a_del_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEL && n_state == S_DONE)
        |=> (r_count == $past(r_count) - CW'(1)))
        else $error("delete did not lower pair count");
`endif

endmodule

### tb/sorted_kern_pair_table_core_test.sv
`timescale 1ns / 1ps

module sorted_kern_pair_table_core_test;
    import skpt_pkg::*;

    localparam int TBL_DEPTH = 256;
    localparam int RUN_LIMIT = 3_000_000;
    // Spare kind code, handled like a lookup
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    // first_char[7:0], second_char[15:8], new_offset[23:16]
    logic [23:0] s_data = '0;
    // kind[1:0]
    logic [1:0]  s_user = '0;
    logic        s_valid = 1'b0;
    wire         s_ready;
    // found[0], pair_offset[8:1], pair_position[16:9], pair_total[25:17],
    // first_entry_valid[26], first_entry_position[34:27], status[36:35], zero[39:37]
    wire  [39:0] m_data;
    wire         m_valid;
    logic        m_ready = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_idx = 1'b0;
    logic [8:0]  cfg_data = '0;

    typedef struct packed {
        logic       found;
        logic [7:0] offset;
        logic [7:0] position;
        logic [8:0] total;
        logic       lead_valid;
        logic [7:0] lead_position;
        logic [1:0] status;
    } t_kern_reply;

    t_kern_reply kern_replies_due[$];

    // Mirror of the pair table, characters relative to cur_first_code
    logic [7:0] tbl_left  [TBL_DEPTH];
    logic [7:0] tbl_right [TBL_DEPTH];
    logic [7:0] tbl_off   [TBL_DEPTH];
    int         tbl_count = 0;
    int         cur_first_code = 32;
    int         cur_glyph_count = 96;

    int err_count = 0;
    int cycle_count = 0;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int rx_hold_req = 0;
    int rx_hold_left = 0;
    int rx_gap_left = 0;

    sorted_kern_pair_table_core #(
        .MAX_PAIRS(TBL_DEPTH)
    ) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("sorted_kern_pair_table_core_test: done, errors");
            $finish;
        end
    end

    function automatic int idle_len();
        return int'(($urandom_range(0, 9) == 0) ? $urandom_range(12, 80)
                                                : $urandom_range(1, 3));
    endfunction

    function automatic logic [7:0] nz_offset();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endfunction

    // Apply one item to the mirror table and return the word it should produce
    function automatic t_kern_reply compute_kern_reply(logic [1:0] kind, logic [7:0] c1,
                                                       logic [7:0] c2, logic [7:0] off);
        t_kern_reply r;
        int span, a, b, l1, l2, at, i;
        bit hit;
        r = '0;
        hit = 1'b0;
        at = 0;
        a = int'(c1);
        b = int'(c2);
        span = (cur_glyph_count > int'(MAX_GLYPHS)) ? int'(MAX_GLYPHS) : cur_glyph_count;
        l1 = a - cur_first_code;
        l2 = b - cur_first_code;
        if (kind == KIND_CLEAR) begin
            tbl_count = 0;
        end else if (l1 < 0 || l2 < 0 || l1 >= span || l2 >= span) begin
            r.status = ST_RANGE;
        end else begin
            for (i = 0; i < tbl_count; i++)
                if (!hit && tbl_left[i] == l1 && tbl_right[i] == l2) begin
                    hit = 1'b1;
                    at = i;
                end
            if (kind == KIND_SET) begin
                if (hit && off == 8'd0) begin
                    // close the gap left by the removed pair
                    for (i = at; i < tbl_count - 1; i++) begin
                        tbl_left[i]  = tbl_left[i + 1];
                        tbl_right[i] = tbl_right[i + 1];
                        tbl_off[i]   = tbl_off[i + 1];
                    end
                    tbl_count--;
                    hit = 1'b0;
                end else if (hit) begin
                    tbl_off[at] = off;
                end else if (off != 8'd0) begin
                    if (tbl_count >= TBL_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        while (at < tbl_count &&
                               {tbl_left[at], tbl_right[at]} < {l1[7:0], l2[7:0]})
                            at++;
                        for (i = tbl_count; i > at; i--) begin
                            tbl_left[i]  = tbl_left[i - 1];
                            tbl_right[i] = tbl_right[i - 1];
                            tbl_off[i]   = tbl_off[i - 1];
                        end
                        tbl_left[at]  = l1[7:0];
                        tbl_right[at] = l2[7:0];
                        tbl_off[at]   = off;
                        tbl_count++;
                        hit = 1'b1;
                    end
                end
            end
            if (hit) begin
                r.found    = 1'b1;
                r.offset   = tbl_off[at];
                r.position = at[7:0];
            end
            // walk down so the lowest position wins
            for (i = tbl_count - 1; i >= 0; i--)
                if (tbl_left[i] == l1) begin
                    r.lead_valid    = 1'b1;
                    r.lead_position = i[7:0];
                end
        end
        r.total = tbl_count[8:0];
        return r;
    endfunction

    always @(posedge clk) begin : reply_monitor
        t_kern_reply want;
        logic [39:0] d;
        if (rst_n && m_valid && m_ready) begin
            d = m_data;
            if (kern_replies_due.size() == 0) begin
                err_count++;
                $display("%0t: word %h arrived with nothing outstanding", $time, d);
            end else begin
                want = kern_replies_due.pop_front();
                check_field("found", 16'(want.found), 16'(d[0]));
                check_field("pair_offset", 16'(want.offset), 16'(d[8:1]));
                check_field("pair_position", 16'(want.position), 16'(d[16:9]));
                check_field("pair_total", 16'(want.total), 16'(d[25:17]));
                check_field("first_entry_valid", 16'(want.lead_valid), 16'(d[26]));
                check_field("first_entry_position", 16'(want.lead_position),
                            16'(d[34:27]));
                check_field("status", 16'(want.status), 16'(d[36:35]));
                check_field("zero pad", 16'd0, 16'(d[39:37]));
            end
        end
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else if (rx_gap_left > 0) begin
            rx_gap_left--;
            m_ready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
            rx_gap_left = idle_len() - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Offer one word and hold it until taken; valid stays high for a back-to-back word
    task automatic send_word(logic [1:0] kind, logic [7:0] c1, logic [7:0] c2,
                             logic [7:0] off);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= kind;
        s_data  <= {off, c2, c1};
        @(posedge clk);
        while (s_ready !== 1'b1) @(posedge clk);
        kern_replies_due.push_back(compute_kern_reply(kind, c1, c2, off));
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (kern_replies_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [8:0] val);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_FIRST_CODE)
            cur_first_code = int'(val[7:0]);
        else
            cur_glyph_count = int'(val);
    endtask

    // Mostly in-window traffic with random content, plus some raw noise
    task automatic send_random_item(int base, int win, int noise_pct);
        logic [1:0] kind;
        logic [7:0] c1, c2, off;
        int pick;
        c1 = 8'(base + $urandom_range(0, win - 1));
        c2 = 8'(base + $urandom_range(0, win - 1));
        off = nz_offset();
        pick = $urandom_range(0, 99);
        if (pick < noise_pct) begin
            kind = 2'($urandom_range(0, 3));
            c1 = 8'($urandom_range(0, 255));
            c2 = 8'($urandom_range(0, 255));
            off = 8'($urandom_range(0, 255));
        end else if (pick < 45) begin
            kind = KIND_SET;
        end else if (pick < 58) begin
            kind = KIND_SET;
            off = 8'd0;
        end else if (pick < 92) begin
            kind = KIND_LOOKUP;
        end else if (pick < 98) begin
            kind = KIND_SPARE;
        end else begin
            kind = KIND_CLEAR;
        end
        send_word(kind, c1, c2, off);
    endtask

    // Reset registers: glyphs 32..127
    task automatic test_directed();
        send_word(KIND_LOOKUP, 8'd32, 8'd32, 8'd0);
        send_word(KIND_SET, 8'd32, 8'd32, 8'h80);
        send_word(KIND_SET, 8'd127, 8'd127, 8'h7F);
        send_word(KIND_SET, 8'd65, 8'd66, 8'h01);
        send_word(KIND_SET, 8'd65, 8'd65, 8'hFF);
        send_word(KIND_LOOKUP, 8'd65, 8'd66, 8'd0);
        send_word(KIND_LOOKUP, 8'd65, 8'd67, 8'd0);
        send_word(KIND_SET, 8'd65, 8'd66, 8'h05);
        send_word(KIND_SPARE, 8'd65, 8'd66, 8'h33);
        send_word(KIND_SET, 8'd65, 8'd65, 8'd0);
        send_word(KIND_SET, 8'd100, 8'd100, 8'd0);
        send_word(KIND_LOOKUP, 8'd31, 8'd32, 8'd0);
        send_word(KIND_LOOKUP, 8'd32, 8'd128, 8'd0);
        send_word(KIND_SET, 8'd0, 8'd255, 8'h09);
        send_word(KIND_SET, 8'd255, 8'd0, 8'h09);
        send_word(KIND_LOOKUP, 8'd128, 8'd127, 8'd0);
        send_word(KIND_CLEAR, 8'd255, 8'd0, 8'hAA);
        send_word(KIND_LOOKUP, 8'd127, 8'd127, 8'd0);
        send_word(KIND_SET, 8'd127, 8'd32, 8'h80);
        send_word(KIND_SPARE, 8'd0, 8'd0, 8'd0);
        send_word(KIND_CLEAR, 8'd127, 8'd32, 8'h55);
        send_word(KIND_LOOKUP, 8'd127, 8'd32, 8'd0);
    endtask

    // Register extremes, and stored pairs read back against new registers
    task automatic test_register_sweep();
        write_reg(CFG_FIRST_CODE, 9'd0);
        write_reg(CFG_GLYPH_COUNT, 9'd256);
        send_word(KIND_SET, 8'd0, 8'd0, 8'h07);
        send_word(KIND_SET, 8'd255, 8'd255, 8'hF9);
        send_word(KIND_SET, 8'd0, 8'd255, 8'h03);
        send_word(KIND_SET, 8'd255, 8'd0, 8'hFD);
        send_word(KIND_LOOKUP, 8'd255, 8'd255, 8'd0);
        write_reg(CFG_FIRST_CODE, 9'd255);
        write_reg(CFG_GLYPH_COUNT, 9'd1);
        send_word(KIND_LOOKUP, 8'd255, 8'd255, 8'd0);
        send_word(KIND_LOOKUP, 8'd0, 8'd0, 8'd0);
        send_word(KIND_LOOKUP, 8'd254, 8'd255, 8'd0);
        send_word(KIND_SET, 8'd255, 8'd255, 8'd0);
        write_reg(CFG_FIRST_CODE, 9'd200);
        write_reg(CFG_GLYPH_COUNT, 9'd256);
        send_word(KIND_LOOKUP, 8'd255, 8'd255, 8'd0);
        send_word(KIND_LOOKUP, 8'd200, 8'd200, 8'd0);
        send_word(KIND_SET, 8'd255, 8'd200, 8'h11);
        send_word(KIND_CLEAR, 8'd0, 8'd0, 8'd0);
    endtask

    // Fill all slots in shuffled order, then push past the limit
    task automatic test_full_table();
        int keys[289];
        int i, j, t, base;
        base = $urandom_range(0, 200);
        write_reg(CFG_FIRST_CODE, 9'(base));
        write_reg(CFG_GLYPH_COUNT, 9'd17);
        send_word(KIND_CLEAR, 8'd0, 8'd0, 8'd0);
        for (i = 0; i < 289; i++)
            keys[i] = i;
        for (i = 288; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = keys[i];
            keys[i] = keys[j];
            keys[j] = t;
        end
        for (i = 0; i < TBL_DEPTH; i++)
            send_word(KIND_SET, 8'(base + keys[i] / 17), 8'(base + keys[i] % 17),
                      nz_offset());
        send_word(KIND_SET, 8'(base + keys[256] / 17), 8'(base + keys[256] % 17),
                  nz_offset());
        send_word(KIND_SET, 8'(base + keys[257] / 17), 8'(base + keys[257] % 17), 8'd0);
        send_word(KIND_SET, 8'(base + keys[3] / 17), 8'(base + keys[3] % 17), nz_offset());
        send_word(KIND_LOOKUP, 8'(base + keys[0] / 17), 8'(base + keys[0] % 17), 8'd0);
        send_word(KIND_SET, 8'(base + keys[5] / 17), 8'(base + keys[5] % 17), 8'd0);
        send_word(KIND_SET, 8'(base + keys[258] / 17), 8'(base + keys[258] % 17),
                  nz_offset());
        send_word(KIND_SET, 8'(base + keys[259] / 17), 8'(base + keys[259] % 17),
                  nz_offset());
        send_word(KIND_CLEAR, 8'd0, 8'd0, 8'd0);
    endtask

    // Long receiver hold while words keep coming, then a full drain mid-stream
    task automatic test_backpressure();
        write_reg(CFG_FIRST_CODE, 9'd40);
        write_reg(CFG_GLYPH_COUNT, 9'd10);
        tx_idle_en = 1'b0;
        rx_hold_req = 1500;
        repeat (12) send_random_item(40, 10, 0);
        tx_idle_en = 1'b1;
        settle();
        repeat (12) send_random_item(40, 10, 5);
    endtask

    task automatic test_random_mix();
        int phase, fc, gc, valid_n, win, base;
        for (phase = 0; phase < 9; phase++) begin
            case (phase)
                0: begin fc = 0;   gc = 1;   end
                1: begin fc = 255; gc = 256; end
                2: begin fc = 0;   gc = 256; end
                3: begin fc = 255; gc = 1;   end
                default: begin
                    fc = $urandom_range(0, 255);
                    gc = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 256)
                                                     : $urandom_range(1, 12);
                end
            endcase
            write_reg(CFG_FIRST_CODE, 9'(fc));
            write_reg(CFG_GLYPH_COUNT, 9'(gc));
            valid_n = (gc < 256 - fc) ? gc : 256 - fc;
            win = (valid_n < 8) ? valid_n : $urandom_range(2, 8);
            base = fc + $urandom_range(0, valid_n - win);
            // every third phase runs without idling
            tx_idle_en = (phase % 3 != 0);
            rx_idle_en = (phase % 3 != 0);
            if ($urandom_range(0, 1) == 1)
                send_word(KIND_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
            repeat (70) send_random_item(base, win, 8);
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_register_sweep();
        test_full_table();
        test_backpressure();
        test_random_mix();
        settle();
        repeat (600) @(posedge clk);
        if (err_count == 0)
            $display("sorted_kern_pair_table_core_test: done, clean");
        else
            $display("sorted_kern_pair_table_core_test: done, errors");
        $finish;
    end

endmodule

### sim.f
rtl/skpt_pkg.sv
rtl/skpt_ram.sv
rtl/sorted_kern_pair_table_core.sv
tb/sorted_kern_pair_table_core_test.sv
